// ===== hw/rtl/quaternion_to_euler_angles_defines.svh =====
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define QTE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qte port check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define QTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qte port check failed");

`endif

// ===== hw/rtl/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: package
// Widths, constants, sideband type and the CORDIC angle table.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 24;

  localparam int QW    = 16;  // quaternion component
  localparam int PRW   = 32;  // 16x16 product
  localparam int SW    = 34;  // product sums, Q30
  localparam int RADW  = 33;  // clamped radicand, Q30
  localparam int ROOTW = 32;  // square root, Q30
  localparam int CW    = 37;  // CORDIC x/y datapath
  localparam int AW    = 36;  // CORDIC angle, Q30 radians
  localparam int RW    = 16;  // roll/yaw output
  localparam int PW    = 15;  // pitch output

  localparam int LN        = 3;
  localparam int LANE_ROLL = 0;
  localparam int LANE_YAW  = 1;
  localparam int LANE_PIT  = 2;

  localparam int ROLL_LIM  = 25736;
  localparam int PITCH_LIM = 12868;

  localparam logic signed [SW-1:0] Q30_ONE = 34'sd1073741824;
  localparam logic signed [AW-1:0] HALF_PI = 36'sd1686629713;

  typedef struct packed {
    logic signed [SW-1:0] sr;
    logic signed [SW-1:0] cr;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] cy;
    logic                 clamp;
  } side_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic [29:0] atan_entry(input int unsigned idx);
    logic [29:0] e;
    case (idx)
      0: e = 30'd843314856;
      1: e = 30'd497837829;
      2: e = 30'd263043836;
      3: e = 30'd133525158;
      4: e = 30'd67021686;
      5: e = 30'd33543515;
      6: e = 30'd16775850;
      7: e = 30'd8388437;
      8: e = 30'd4194282;
      9: e = 30'd2097149;
      default: e = 30'((32'd1 << (30 - idx)) - 32'd1);
    endcase
    return e;
  endfunction

endpackage

// ===== hw/rtl/qte_front.sv =====
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: front end
// Two stages: component products, then product sums and radicand clamp.
// ----------------------------------------------------------------------------
module qte_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic signed [qte_pkg::QW-1:0]      w,
  input  logic signed [qte_pkg::QW-1:0]      x,
  input  logic signed [qte_pkg::QW-1:0]      y,
  input  logic signed [qte_pkg::QW-1:0]      z,
  output logic                               out_vld,
  output qte_pkg::side_t                     side,
  output logic [qte_pkg::RADW-1:0]           ra,
  output logic [qte_pkg::RADW-1:0]           rb
);

  localparam int SW = qte_pkg::SW;

  logic                            vld1_r, vld2_r;
  logic signed [qte_pkg::PRW-1:0]  wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, xz_r;
  qte_pkg::side_t                  side_r, side_nxt;
  logic [qte_pkg::RADW-1:0]        ra_r, rb_r, ra_nxt, rb_nxt;
  logic signed [SW-1:0]            t2;
  logic signed [SW:0]              ra_s, rb_s;

  always_comb begin
    side_nxt.sr = (SW'(wx_r) + SW'(yz_r)) <<< 1;
    side_nxt.cr = qte_pkg::Q30_ONE - ((SW'(xx_r) + SW'(yy_r)) <<< 1);
    side_nxt.sy = (SW'(wz_r) + SW'(xy_r)) <<< 1;
    side_nxt.cy = qte_pkg::Q30_ONE - ((SW'(yy_r) + SW'(zz_r)) <<< 1);
    t2          = (SW'(wy_r) - SW'(xz_r)) <<< 1;
    ra_s        = (SW + 1)'(qte_pkg::Q30_ONE) + (SW + 1)'(t2);
    rb_s        = (SW + 1)'(qte_pkg::Q30_ONE) - (SW + 1)'(t2);
    // clamp a negative radicand to zero and flag it
    ra_nxt        = ra_s[SW] ? '0 : ra_s[qte_pkg::RADW-1:0];
    rb_nxt        = rb_s[SW] ? '0 : rb_s[qte_pkg::RADW-1:0];
    side_nxt.clamp = ra_s[SW] | rb_s[SW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r   <= w * x;
      yz_r   <= y * z;
      xx_r   <= x * x;
      yy_r   <= y * y;
      wz_r   <= w * z;
      xy_r   <= x * y;
      zz_r   <= z * z;
      wy_r   <= w * y;
      xz_r   <= x * z;
      side_r <= side_nxt;
      ra_r   <= ra_nxt;
      rb_r   <= rb_nxt;
    end
  end

  assign out_vld = vld2_r;
  assign side    = side_r;
  assign ra      = ra_r;
  assign rb      = rb_r;

endmodule

// ===== hw/rtl/qte_isqrt.sv =====
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: square root pipeline
// Two-lane digit-by-digit floor(sqrt(r * 2^30)), one root bit per stage.
// ----------------------------------------------------------------------------
module qte_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  qte_pkg::side_t                side_in,
  input  logic [qte_pkg::RADW-1:0]      ra,
  input  logic [qte_pkg::RADW-1:0]      rb,
  output logic                          out_vld,
  output qte_pkg::side_t                side_out,
  output logic [qte_pkg::ROOTW-1:0]     root_a,
  output logic [qte_pkg::ROOTW-1:0]     root_b
);

  localparam int NST  = qte_pkg::ROOTW;
  localparam int RADW = qte_pkg::RADW;
  localparam int REMW = qte_pkg::ROOTW + 4;
  localparam int VW   = 2 * qte_pkg::ROOTW;

  logic                         vld_r    [NST];
  qte_pkg::side_t               side_r   [NST];
  logic [RADW-1:0]              rad_r    [NST][2];
  logic [REMW-1:0]              rem_r    [NST][2];
  logic [NST-1:0]               root_r   [NST][2];
  logic                         vld_nxt  [NST];
  qte_pkg::side_t               side_nxt [NST];
  logic [RADW-1:0]              rad_nxt  [NST][2];
  logic [REMW-1:0]              rem_nxt  [NST][2];
  logic [NST-1:0]               root_nxt [NST][2];

  always_comb begin
    logic [RADW-1:0] rad;
    logic [REMW-1:0] rem, remsh, trial;
    logic [NST-1:0]  root;
    logic [VW-1:0]   v;
    for (int k = 0; k < NST; k++) begin
      vld_nxt[k]  = (k == 0) ? in_vld  : vld_r[k-1];
      side_nxt[k] = (k == 0) ? side_in : side_r[k-1];
      for (int l = 0; l < 2; l++) begin
        if (k == 0) begin
          rad  = (l == 0) ? ra : rb;
          rem  = '0;
          root = '0;
        end else begin
          rad  = rad_r[k-1][l];
          rem  = rem_r[k-1][l];
          root = root_r[k-1][l];
        end
        v     = {{(VW - RADW - 30){1'b0}}, rad, 30'b0};
        remsh = {rem[REMW-3:0], v[2*(NST-1-k) +: 2]};
        trial = REMW'({root, 2'b01});
        rad_nxt[k][l] = rad;
        if (remsh >= trial) begin
          rem_nxt[k][l]  = remsh - trial;
          root_nxt[k][l] = {root[NST-2:0], 1'b1};
        end else begin
          rem_nxt[k][l]  = remsh;
          root_nxt[k][l] = {root[NST-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign out_vld  = vld_r[NST-1];
  assign side_out = side_r[NST-1];
  assign root_a   = root_r[NST-1][0];
  assign root_b   = root_r[NST-1][1];

endmodule

// ===== hw/rtl/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: CORDIC pipeline
// Three-lane vectoring atan2: a quadrant stage, then one micro-rotation per stage.
// ----------------------------------------------------------------------------
module qte_cordic #(
  parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic                             clamp_in,
  input  logic signed [qte_pkg::CW-1:0]    x_in [qte_pkg::LN],
  input  logic signed [qte_pkg::CW-1:0]    y_in [qte_pkg::LN],
  output logic                             out_vld,
  output logic                             clamp_out,
  output logic signed [qte_pkg::AW-1:0]    ang_out [qte_pkg::LN],
  output logic                             zero_out [qte_pkg::LN]
);

  localparam int NS  = (STEPS < qte_pkg::MAX_STEPS) ? STEPS : qte_pkg::MAX_STEPS;
  localparam int NST = NS + 1;
  localparam int LN  = qte_pkg::LN;
  localparam int CW  = qte_pkg::CW;
  localparam int AW  = qte_pkg::AW;

  logic                 vld_r     [NST];
  logic                 clamp_r   [NST];
  logic signed [CW-1:0] x_r       [NST][LN];
  logic signed [CW-1:0] y_r       [NST][LN];
  logic signed [AW-1:0] a_r       [NST][LN];
  logic                 z_r       [NST][LN];
  logic                 vld_nxt   [NST];
  logic                 clamp_nxt [NST];
  logic signed [CW-1:0] x_nxt     [NST][LN];
  logic signed [CW-1:0] y_nxt     [NST][LN];
  logic signed [AW-1:0] a_nxt     [NST][LN];
  logic                 z_nxt     [NST][LN];

  always_comb begin
    logic signed [CW-1:0] xv, yv, xs, ys;
    logic signed [AW-1:0] av, ent;
    for (int k = 0; k < NST; k++) begin
      vld_nxt[k]   = (k == 0) ? in_vld   : vld_r[k-1];
      clamp_nxt[k] = (k == 0) ? clamp_in : clamp_r[k-1];
      for (int l = 0; l < LN; l++) begin
        if (k == 0) begin
          // fold the left half-plane onto the right
          xv = x_in[l];
          yv = y_in[l];
          z_nxt[k][l] = (xv == '0) && (yv == '0);
          if (xv < 0) begin
            if (yv >= 0) begin
              x_nxt[k][l] = yv;
              y_nxt[k][l] = -xv;
              a_nxt[k][l] = qte_pkg::HALF_PI;
            end else begin
              x_nxt[k][l] = -yv;
              y_nxt[k][l] = xv;
              a_nxt[k][l] = -qte_pkg::HALF_PI;
            end
          end else begin
            x_nxt[k][l] = xv;
            y_nxt[k][l] = yv;
            a_nxt[k][l] = '0;
          end
        end else begin
          xv  = x_r[k-1][l];
          yv  = y_r[k-1][l];
          av  = a_r[k-1][l];
          xs  = xv >>> (k - 1);
          ys  = yv >>> (k - 1);
          ent = $signed({{(AW - 30){1'b0}}, qte_pkg::atan_entry(k - 1)});
          z_nxt[k][l] = z_r[k-1][l];
          if (yv < 0) begin
            x_nxt[k][l] = xv - ys;
            y_nxt[k][l] = yv + xs;
            a_nxt[k][l] = av - ent;
          end else begin
            x_nxt[k][l] = xv + ys;
            y_nxt[k][l] = yv - xs;
            a_nxt[k][l] = av + ent;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clamp_r <= clamp_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      a_r     <= a_nxt;
      z_r     <= z_nxt;
    end
  end

  assign out_vld   = vld_r[NST-1];
  assign clamp_out = clamp_r[NST-1];
  assign ang_out   = a_r[NST-1];
  assign zero_out  = z_r[NST-1];

endmodule

// ===== hw/rtl/qte_back.sv =====
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: output stage
// Pitch rescale, rounding to Q3.13 (pitch Q2.13), saturation, and the output register.
// ----------------------------------------------------------------------------
module qte_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic                             clamp_in,
  input  logic signed [qte_pkg::AW-1:0]    ang [qte_pkg::LN],
  input  logic                             zero [qte_pkg::LN],
  output logic                             out_vld,
  output logic signed [qte_pkg::RW-1:0]    roll,
  output logic signed [qte_pkg::PW-1:0]    pitch,
  output logic signed [qte_pkg::RW-1:0]    yaw,
  output logic                             clamped
);

  localparam int AW = qte_pkg::AW;

  logic                         vld_r, clamp_r;
  logic signed [qte_pkg::RW-1:0] roll_r, yaw_r, roll_nxt, yaw_nxt;
  logic signed [qte_pkg::PW-1:0] pitch_r, pitch_nxt;
  logic signed [AW:0]            a_roll, a_yaw, a_pit;

  // round Q30 to Q13 toward the nearest, then saturate
  function automatic logic signed [AW:0] to_q13(input logic signed [AW:0] a, input int lim);
    logic signed [AW:0] r, lv;
    lv = (AW + 1)'(lim);
    r  = (a + (AW + 1)'(65536)) >>> 17;
    if (r > lv) r = lv;
    if (r < -lv) r = -lv;
    return r;
  endfunction

  always_comb begin
    a_roll = zero[qte_pkg::LANE_ROLL] ? '0 : (AW + 1)'(ang[qte_pkg::LANE_ROLL]);
    a_yaw  = zero[qte_pkg::LANE_YAW]  ? '0 : (AW + 1)'(ang[qte_pkg::LANE_YAW]);
    a_pit  = zero[qte_pkg::LANE_PIT]  ? '0 : (AW + 1)'(ang[qte_pkg::LANE_PIT]);
    a_pit  = (a_pit <<< 1) - (AW + 1)'(qte_pkg::HALF_PI);
    roll_nxt  = qte_pkg::RW'(to_q13(a_roll, qte_pkg::ROLL_LIM));
    yaw_nxt   = qte_pkg::RW'(to_q13(a_yaw, qte_pkg::ROLL_LIM));
    pitch_nxt = qte_pkg::PW'(to_q13(a_pit, qte_pkg::PITCH_LIM));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= roll_nxt;
      yaw_r   <= yaw_nxt;
      pitch_r <= pitch_nxt;
      clamp_r <= clamp_in;
    end
  end

  assign out_vld = vld_r;
  assign roll    = roll_r;
  assign pitch   = pitch_r;
  assign yaw     = yaw_r;
  assign clamped = clamp_r;

endmodule

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
// ----------------------------------------------------------------------------
// Quaternion to Euler angles (Z-Y-X)
// Unit quaternion in Q1.15 to roll and yaw in Q3.13 and pitch in Q2.13 radians.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------
//   in_     | input     | in_valid / in_ready    | quat_w, quat_x, quat_y, quat_z
//   out_    | output    | out_valid / out_ready  | roll, pitch, yaw, clamp flag
//
// One item per cycle while no result is held at the output; the pipeline
// depth is set by the 32-stage root pipeline and the CORDIC stage count
// (capped at 24 steps).
// Reset clears only the valid bits; no state carries between items.
// A stall at the output freezes every stage at once; in_ready drops only
// while a result sits in the output register unaccepted.
//
module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [qte_pkg::QW-1:0]   in_quat_w,
  input  logic signed [qte_pkg::QW-1:0]   in_quat_x,
  input  logic signed [qte_pkg::QW-1:0]   in_quat_y,
  input  logic signed [qte_pkg::QW-1:0]   in_quat_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [qte_pkg::RW-1:0]   out_roll_angle,
  output logic signed [qte_pkg::PW-1:0]   out_pitch_angle,
  output logic signed [qte_pkg::RW-1:0]   out_yaw_angle,
  output logic                            out_radicand_clamped
);

  localparam int CW = qte_pkg::CW;
  localparam int LN = qte_pkg::LN;

  logic                         adv;
  logic                         f_vld, s_vld, c_vld, c_clamp;
  qte_pkg::side_t               f_side, s_side;
  logic [qte_pkg::RADW-1:0]     f_ra, f_rb;
  logic [qte_pkg::ROOTW-1:0]    s_root_a, s_root_b;
  logic signed [CW-1:0]         cx [LN];
  logic signed [CW-1:0]         cy [LN];
  logic signed [qte_pkg::AW-1:0] c_ang [LN];
  logic                         c_zero [LN];

  // advance the whole pipeline unless a result is held at the output
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  qte_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_vld (in_valid),
    .w      (in_quat_w),
    .x      (in_quat_x),
    .y      (in_quat_y),
    .z      (in_quat_z),
    .out_vld(f_vld),
    .side   (f_side),
    .ra     (f_ra),
    .rb     (f_rb)
  );

  // sqrt(1+2t) and sqrt(1-2t); the roll/yaw sums ride along as sideband
  qte_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (f_vld),
    .side_in (f_side),
    .ra      (f_ra),
    .rb      (f_rb),
    .out_vld (s_vld),
    .side_out(s_side),
    .root_a  (s_root_a),
    .root_b  (s_root_b)
  );

  // lane inputs: roll = atan2(sr, cr), yaw = atan2(sy, cy), pitch = atan2(sa, sb)
  always_comb begin
    cx[qte_pkg::LANE_ROLL] = CW'(s_side.cr);
    cy[qte_pkg::LANE_ROLL] = CW'(s_side.sr);
    cx[qte_pkg::LANE_YAW]  = CW'(s_side.cy);
    cy[qte_pkg::LANE_YAW]  = CW'(s_side.sy);
    cx[qte_pkg::LANE_PIT]  = $signed({{(CW - qte_pkg::ROOTW){1'b0}}, s_root_b});
    cy[qte_pkg::LANE_PIT]  = $signed({{(CW - qte_pkg::ROOTW){1'b0}}, s_root_a});
  end

  qte_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (s_vld),
    .clamp_in (s_side.clamp),
    .x_in     (cx),
    .y_in     (cy),
    .out_vld  (c_vld),
    .clamp_out(c_clamp),
    .ang_out  (c_ang),
    .zero_out (c_zero)
  );

  qte_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (c_vld),
    .clamp_in(c_clamp),
    .ang     (c_ang),
    .zero    (c_zero),
    .out_vld (out_valid),
    .roll    (out_roll_angle),
    .pitch   (out_pitch_angle),
    .yaw     (out_yaw_angle),
    .clamped (out_radicand_clamped)
  );

endmodule

// ===== hw/rtl/qte_checker.sv =====
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: port checker
// Output hold, backpressure coupling and angle range checks.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_defines.svh"

module qte_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [qte_pkg::RW-1:0]   out_roll_angle,
  input logic signed [qte_pkg::PW-1:0]   out_pitch_angle,
  input logic signed [qte_pkg::RW-1:0]   out_yaw_angle,
  input logic                            out_radicand_clamped
);

  logic [qte_pkg::RW+qte_pkg::PW+qte_pkg::RW:0] out_bus;
  logic                                         pitch_in_range;
  logic                                         roll_yaw_in_range;

  assign out_bus = {out_roll_angle, out_pitch_angle, out_yaw_angle, out_radicand_clamped};

  assign pitch_in_range    = (out_pitch_angle <= 15'sd12868) &&
                             (out_pitch_angle >= -15'sd12868);
  assign roll_yaw_in_range = (out_roll_angle <= 16'sd25736) &&
                             (out_roll_angle >= -16'sd25736) &&
                             (out_yaw_angle <= 16'sd25736) &&
                             (out_yaw_angle >= -16'sd25736);

  `QTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `QTE_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_bus))
  `QTE_ASSERT_NOW(a_stall_blocks_in, out_valid && !out_ready, !in_ready)
  `QTE_ASSERT_NOW(a_pitch_range, out_valid, pitch_in_range)
  `QTE_ASSERT_NOW(a_roll_yaw_range, out_valid, roll_yaw_in_range)

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_roll_angle      (out_roll_angle),
  .out_pitch_angle     (out_pitch_angle),
  .out_yaw_angle       (out_yaw_angle),
  .out_radicand_clamped(out_radicand_clamped)
);

// ===== tb/tb_quaternion_to_euler_angles.sv =====
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: testbench
// Drives quaternions through the valid/ready input, predicts roll, pitch and
// yaw with a local fixed-point CORDIC model, and compares every result in order.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QW         = qte_pkg::QW;
  localparam int RW         = qte_pkg::RW;
  localparam int PW         = qte_pkg::PW;
  localparam int MAX_STEPS  = qte_pkg::MAX_STEPS;
  localparam int ROLL_LIM   = qte_pkg::ROLL_LIM;
  localparam int PITCH_LIM  = qte_pkg::PITCH_LIM;
  localparam int STEPS      = qte_pkg::CORDIC_STEPS_DEF;
  localparam int LATENCY    = 2 + 32 + STEPS + 1 + 1;
  localparam int WATCHDOG   = 4000;
  localparam int N_RANDOM   = 1950;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint PI_2Q30 = 64'sd1686629713;

  typedef struct {
    logic signed [QW-1:0] w, x, y, z;
  } quat_t;

  typedef struct {
    logic signed [RW-1:0] roll;
    logic signed [PW-1:0] pitch;
    logic signed [RW-1:0] yaw;
    logic                 clamp;
  } euler_t;

  // Directed row: quaternion, plus an expected result where it is obvious.
  typedef struct {
    quat_t  q;
    bit     fixed;
    euler_t e;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [QW-1:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [RW-1:0] out_roll_angle;
  logic signed [PW-1:0] out_pitch_angle;
  logic signed [RW-1:0] out_yaw_angle;
  logic out_radicand_clamped;

  euler_t pending_angles[$];
  int     errors = 0;
  int     idle_cycles = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  quaternion_to_euler_angles uut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_quat_w, .in_quat_x, .in_quat_y, .in_quat_z,
    .out_valid, .out_ready,
    .out_roll_angle, .out_pitch_angle, .out_yaw_angle, .out_radicand_clamped
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: exact Q30 products, integer square root, vectoring CORDIC.
  // --------------------------------------------------------------------------
  function automatic longint atan_q30(int i);
    longint tab[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                        33543515, 16775850, 8388437, 4194282, 2097149};
    if (i < 10) return tab[i];
    return (64'sd1 <<< (30 - i)) - 1;
  endfunction

  function automatic longint root_q30(longint r);
    // floor(sqrt(r * 2^30)), bit-by-bit
    logic [63:0] v, res, b;
    v = 64'(r) << 30;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vector_angle(longint yy, longint xx);
    longint ang, t, xs, ys;
    ang = 0;
    if (xx == 0 && yy == 0) return 0;
    if (xx < 0) begin
      t = xx;
      if (yy >= 0) begin
        xx = yy; yy = -t; ang = PI_2Q30;
      end else begin
        xx = -yy; yy = t; ang = -PI_2Q30;
      end
    end
    for (int i = 0; i < STEPS && i < MAX_STEPS; i++) begin
      xs = xx >>> i;
      ys = yy >>> i;
      if (yy < 0) begin
        xx -= ys; yy += xs; ang -= atan_q30(i);
      end else begin
        xx += ys; yy -= xs; ang += atan_q30(i);
      end
    end
    return ang;
  endfunction

  function automatic longint round_q13(longint a, longint lim);
    longint r;
    r = (a + (64'sd1 <<< 16)) >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t predict_angles(quat_t q);
    longint w, x, y, z, sr, cr, sy, cy, t2, ra, rb;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    sr = 2 * (w * x + y * z);
    cr = ONE_Q30 - 2 * (x * x + y * y);
    sy = 2 * (w * z + x * y);
    cy = ONE_Q30 - 2 * (y * y + z * z);
    t2 = 2 * (w * y - x * z);
    ra = ONE_Q30 + t2;
    rb = ONE_Q30 - t2;
    e.clamp = 1'b0;
    // Clamp a negative radicand (non-unit quaternion) and flag it.
    if (ra < 0) begin ra = 0; e.clamp = 1'b1; end
    if (rb < 0) begin rb = 0; e.clamp = 1'b1; end
    e.roll  = RW'(round_q13(vector_angle(sr, cr), ROLL_LIM));
    e.pitch = PW'(round_q13(2 * vector_angle(root_q30(ra), root_q30(rb)) - PI_2Q30,
                            PITCH_LIM));
    e.yaw   = RW'(round_q13(vector_angle(sy, cy), ROLL_LIM));
    return e;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic quat_t random_quat();
    quat_t q;
    real a, b, c, d, n;
    case ($urandom_range(9))
      0: begin
        // raw noise: non-unit, often clamped
        q.w = 16'($urandom); q.x = 16'($urandom); q.y = 16'($urandom); q.z = 16'($urandom);
      end
      1: begin
        // near gimbal lock: wy - xz close to +-1/2
        q.w = 16'sd23170 + $signed(16'($urandom_range(64))) - 16'sd32;
        q.y = ($urandom_range(1)) ? q.w : -q.w;
        q.x = $signed(16'($urandom_range(64))) - 16'sd32;
        q.z = $signed(16'($urandom_range(64))) - 16'sd32;
      end
      default: begin
        // roughly unit quaternion with random direction
        a = real'($urandom_range(65534)) - 32767.0;
        b = real'($urandom_range(65534)) - 32767.0;
        c = real'($urandom_range(65534)) - 32767.0;
        d = real'($urandom_range(65534)) - 32767.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) begin a = 32767.0; n = 32767.0; end
        q.w = 16'($rtoi(a / n * 32767.0));
        q.x = 16'($rtoi(b / n * 32767.0));
        q.y = 16'($rtoi(c / n * 32767.0));
        q.z = 16'($rtoi(d / n * 32767.0));
      end
    endcase
    return q;
  endfunction

  // Idle if asked, present one item, hold it until accepted, return on the
  // falling edge with valid still high.
  task automatic send_quat(quat_t q, euler_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_quat_w <= q.w;
    in_quat_x <= q.x;
    in_quat_y <= q.y;
    in_quat_z <= q.z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_angles.push_back(e);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has come.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_angles.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall, check on accept
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    euler_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_angles.size() == 0) begin
        $error("result with no pending item");
        errors++;
      end else begin
        e = pending_angles.pop_front();
        if (out_roll_angle !== e.roll) begin
          $error("roll_angle: expected %0d, got %0d", e.roll, out_roll_angle);
          errors++;
        end
        if (out_pitch_angle !== e.pitch) begin
          $error("pitch_angle: expected %0d, got %0d", e.pitch, out_pitch_angle);
          errors++;
        end
        if (out_yaw_angle !== e.yaw) begin
          $error("yaw_angle: expected %0d, got %0d", e.yaw, out_yaw_angle);
          errors++;
        end
        if (out_radicand_clamped !== e.clamp) begin
          $error("radicand_clamped: expected %0b, got %0b", e.clamp,
                 out_radicand_clamped);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    quat_t    q;
    int       phase;

    // Identity and its negation give all-zero angles; only the identity row fixes that, the rest is predicted.
    rows.push_back('{'{16'sd32767, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{0, 0, 0, 1'b0}});
    rows.push_back('{'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '{0, 0, 0, 1'b0}});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '{0, 0, 0, 1'b0}});
    rows.push_back('{'{16'sd0, 16'sd32767, 16'sd0, 16'sd0}, 1'b0, '{0, 0, 0, 1'b0}});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd32767, 16'sd0}, 1'b0, '{0, 0, 0, 1'b0}});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd32767}, 1'b0, '{0, 0, 0, 1'b0}});
    rows.push_back('{'{16'sd23170, 16'sd0, 16'sd23170, 16'sd0}, 1'b0, '{0, 0, 0, 1'b0}});
    rows.push_back('{'{16'sd23170, 16'sd0, -16'sd23170, 16'sd0}, 1'b0, '{0, 0, 0, 1'b0}});
    rows.push_back('{'{16'sd23170, 16'sd23170, 16'sd0, 16'sd0}, 1'b0, '{0, 0, 0, 1'b0}});
    rows.push_back('{'{16'sd23170, 16'sd0, 16'sd0, -16'sd23170}, 1'b0, '{0, 0, 0, 1'b0}});
    rows.push_back('{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b0,
                    '{0, 0, 0, 1'b0}});
    rows.push_back('{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b0,
                    '{0, 0, 0, 1'b0}});
    rows.push_back('{'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768}, 1'b0,
                    '{0, 0, 0, 1'b0}});
    rows.push_back('{'{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768}, 1'b0,
                    '{0, 0, 0, 1'b0}});
    rows.push_back('{'{16'sd0, -16'sd32768, 16'sd0, -16'sd32768}, 1'b0, '{0, 0, 0, 1'b0}});
    rows.push_back('{'{-16'sd1, 16'sd1, -16'sd1, 16'sd1}, 1'b0, '{0, 0, 0, 1'b0}});
    rows.push_back('{'{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384}, 1'b0,
                    '{0, 0, 0, 1'b0}});
    rows.push_back('{'{16'sd16384, -16'sd16384, 16'sd16384, 16'sd16384}, 1'b0,
                    '{0, 0, 0, 1'b0}});

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table, no idling.
    foreach (rows[i]) begin
      r = rows[i];
      send_quat(r.q, r.fixed ? r.e : predict_angles(r.q));
    end

    // Random phases: none, sender idle, receiver stall, both.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        q = random_quat();
        send_quat(q, predict_angles(q));
      end
      // Hold the sender until the pipeline has emptied.
      if (phase == 1) drain_results();
    end

    drain_results();
    recv_stall_pct = 0;
    repeat (LATENCY + 8) @(negedge clk);
    if (errors == 0 && pending_angles.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== quaternion_to_euler_angles.f =====
+incdir+hw/rtl
hw/rtl/qte_pkg.sv
hw/rtl/qte_front.sv
hw/rtl/qte_isqrt.sv
hw/rtl/qte_cordic.sv
hw/rtl/qte_back.sv
hw/rtl/quaternion_to_euler_angles.sv
hw/rtl/qte_checker.sv
tb/tb_quaternion_to_euler_angles.sv
